// ===== sv/rlli_pkg.sv =====
// ----------------------------------------------------------------------------
// rlli_pkg
// Types and constants shared by the RGBA lookup table with linear blend:
// colour entry layout, clamp codes, opcodes and input field positions.
// ----------------------------------------------------------------------------
package rlli_pkg;

    // One colour entry: channel 0 red, 1 green, 2 blue, 3 alpha.
    typedef logic [3:0][15:0] t_rgba;

    // Clamp kind reported with each result.
    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_LOW  = 2'd1,
        CLAMP_HIGH = 2'd2
    } t_clamp;

    // Opcodes carried in tuser.
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Input tdata layout, lowest bit first.
    localparam int IN_TDATA_W = 104;
    localparam int IDX_LSB    = 0;
    localparam int COLOR_LSB  = 8;
    localparam int QUERY_LSB  = 72;

    // Table contents after reset.
    localparam t_rgba ENTRY_BLACK = 64'hFFFF_0000_0000_0000;
    localparam t_rgba ENTRY_WHITE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_rgba ENTRY_ZERO  = 64'h0000_0000_0000_0000;

endpackage

// ===== sv/rlli_ram.sv =====
// ----------------------------------------------------------------------------
// rlli_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rlli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rlli_blend.sv =====
// ----------------------------------------------------------------------------
// rlli_blend
// Two-stage linear blend of two colour entries by a fraction, rounding to
// nearest with halves up. Result holds until the next start.
// ----------------------------------------------------------------------------
module rlli_blend #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  rlli_pkg::t_rgba          i_lo,
    input  rlli_pkg::t_rgba          i_hi,
    input  logic [FRACTION_BITS-1:0] i_frac,
    output logic                     o_done,
    output rlli_pkg::t_rgba          o_color
);
    import rlli_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam logic [FB:0]    ONE  = {1'b1, {FB{1'b0}}};
    localparam logic [FB+15:0] HALF = (FB+16)'(1) << (FB - 1);

    logic [FB:0]    weight_lo;
    logic [FB+16:0] prod_lo [4];
    logic [FB+16:0] prod_hi [4];
    logic [FB+15:0] sum     [4];

    logic [FB+15:0] r_prod_lo [4];
    logic [FB+15:0] r_prod_hi [4];
    t_rgba          r_color;
    logic           r_v1;
    logic           r_done;

    // Weight the two entries per channel
    always_comb begin
        weight_lo = ONE - {1'b0, i_frac};
        for (int c = 0; c < 4; c++) begin
            prod_lo[c] = (FB+17)'(i_lo[c]) * (FB+17)'(weight_lo);
            prod_hi[c] = (FB+17)'(i_hi[c]) * (FB+17)'(i_frac);
        end
    end

    // Add the products and the rounding half
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum[c] = r_prod_lo[c] + r_prod_hi[c] + HALF;
        end
    end

    // Products, then rounded sum
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            if (i_start) begin
                r_prod_lo[c] <= prod_lo[c][FB+15:0];
                r_prod_hi[c] <= prod_hi[c][FB+15:0];
            end
            if (r_v1) begin
                r_color[c] <= sum[c][FB+15:FB];
            end
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
    end

    assign o_done  = r_done;
    assign o_color = r_color;

endmodule

// ===== sv/rgba_lut_linear_interp.sv =====
// ----------------------------------------------------------------------------
// rgba_lut_linear_interp
// RGBA colour lookup table with linear interpolation between neighbouring
// entries. Write transfers load an entry, query transfers return one colour.
// ----------------------------------------------------------------------------
// Order: a query passes the scale multiply, table read, two blend stages and
//   output load in turn; no new item is taken until its result has been
//   loaded into the output register, and that load waits while the output stalls.
// Throughput: one write transfer a cycle while no query is in progress.
// Reset: synchronous, active low; a clearing pass then loads black, white and
//   zeros into the table while input tready stays low.
// ----------------------------------------------------------------------------
module rgba_lut_linear_interp #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: entries_in_use
    input  logic         i_cfg_wen,
    input  logic [8:0]   i_cfg_wdata,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: entry_index[7:0], red_in[23:8], green_in[39:24], blue_in[55:40],
    //        alpha_in[71:56], query_value[103:72]
    input  logic [103:0] s_axis_tdata,
    // tuser: opcode[0]
    input  logic         s_axis_tuser,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: red[15:0], green[31:16], blue[47:32], alpha[63:48]
    output logic [63:0]  m_axis_tdata,
    // tuser: clamp_kind[1:0]
    output logic [1:0]   m_axis_tuser
);
    import rlli_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int SW = 31 + AW;
    localparam int WW = SW - FB;
    localparam logic [NW-1:0] DEPTH_N  = NW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_ADR = AW'(TABLE_DEPTH - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_ADDR  = 7'b0001000,
        S_FETCH = 7'b0010000,
        S_BLEND = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    logic [8:0]     r_entries;
    logic [AW-1:0]  r_clr;
    logic [30:0]    r_raw;
    logic           r_neg;
    logic [SW-1:0]  r_scaled;
    logic [FB-1:0]  r_frac;
    t_clamp         r_kind;
    logic           r_m_valid;
    t_rgba          r_m_data;
    t_clamp         r_m_kind;

    logic [NW-1:0]  entries_ext;
    logic [NW-1:0]  entries_eff;
    logic [AW-1:0]  last;
    logic [WW-1:0]  whole;
    logic           in_xfer;
    logic           wr_in_range;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    t_rgba          ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  rd_addr_a;
    logic [AW-1:0]  rd_addr_b;
    t_rgba          rd_data_a;
    t_rgba          rd_data_b;
    logic [FB-1:0]  sel_frac;
    t_clamp         sel_kind;
    logic           blend_done;
    t_rgba          blend_color;
    logic           out_load;

    // Clamp the entry count to between two and the table depth and derive the last index
    always_comb begin
        entries_ext = NW'(r_entries);
        if (entries_ext < NW'(2)) begin
            entries_eff = NW'(2);
        end else if (entries_ext > DEPTH_N) begin
            entries_eff = DEPTH_N;
        end else begin
            entries_eff = entries_ext;
        end
        last = AW'(entries_eff - NW'(1));
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign wr_in_range   = 32'(s_axis_tdata[IDX_LSB +: 8]) < TABLE_DEPTH;
    assign out_load      = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    // Table write: clearing pass or write transfer
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = ENTRY_ZERO;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
            if (r_clr == AW'(0)) begin
                ram_wdata = ENTRY_BLACK;
            end else if (r_clr == AW'(1)) begin
                ram_wdata = ENTRY_WHITE;
            end
        end else if (in_xfer && (s_axis_tuser == OP_WRITE) && wr_in_range) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(s_axis_tdata[IDX_LSB +: 8]);
            ram_wdata = s_axis_tdata[COLOR_LSB +: 64];
        end
    end

    // Split the scaled value and pick the entries to read
    always_comb begin
        whole     = r_scaled[SW-1:FB];
        ram_re    = (r_state == S_ADDR);
        rd_addr_a = AW'(0);
        rd_addr_b = AW'(0);
        sel_frac  = '0;
        sel_kind  = CLAMP_LOW;
        if (r_neg) begin
            sel_kind = CLAMP_LOW;
        end else if (whole >= WW'(last)) begin
            rd_addr_a = last;
            rd_addr_b = last;
            sel_kind  = CLAMP_HIGH;
        end else begin
            rd_addr_a = whole[AW-1:0];
            rd_addr_b = whole[AW-1:0] + AW'(1);
            sel_frac  = r_scaled[FB-1:0];
            sel_kind  = CLAMP_NONE;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == LAST_ADR) n_state = S_IDLE;
            S_IDLE:  if (in_xfer && (s_axis_tuser == OP_QUERY)) n_state = S_SCALE;
            S_SCALE: n_state = S_ADDR;
            S_ADDR:  n_state = S_FETCH;
            S_FETCH: n_state = S_BLEND;
            S_BLEND: if (blend_done) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_entries <= 9'd2;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_wen) begin
                r_entries <= i_cfg_wdata;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Query datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_raw <= s_axis_tdata[QUERY_LSB +: 31];
            r_neg <= s_axis_tdata[QUERY_LSB + 31];
        end
        if (r_state == S_SCALE) begin
            r_scaled <= SW'(r_raw) * SW'(last);
        end
        if (r_state == S_ADDR) begin
            r_frac <= sel_frac;
            r_kind <= sel_kind;
        end
        if (out_load) begin
            r_m_data <= blend_color;
            r_m_kind <= r_kind;
        end
    end

    // Two mirrored copies of the table give both neighbours in one read
    rlli_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr_a),
        .o_rdata (rd_data_a)
    );

    rlli_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr_b),
        .o_rdata (rd_data_b)
    );

    rlli_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_FETCH),
        .i_lo    (rd_data_a),
        .i_hi    (rd_data_b),
        .i_frac  (r_frac),
        .o_done  (blend_done),
        .o_color (blend_color)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

    // Table writes only happen while clearing or between queries
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR) || (r_state == S_IDLE))
        else $error("table write during a query");

    // Blend result arrives only while the sequencer waits for it
    a_blend_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blend_done |-> (r_state == S_BLEND))
        else $error("blend result outside wait state");

    // Never overwrite an untaken result
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !m_axis_tready) |=> !$past(out_load))
        else $error("output overwritten while stalled");

    // Neighbour read stays inside the table
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (rd_addr_b <= LAST_ADR) && (rd_addr_a <= rd_addr_b))
        else $error("table read out of range");

endmodule

// ===== dv/rgba_lut_linear_interp_checker.sv =====
// ----------------------------------------------------------------------------
// rgba_lut_linear_interp_checker
// Watches the configuration port and both streams of the RGBA lookup table.
// It keeps its own copy of the colour table and of entries_in_use, works out
// the colour of every query transfer and compares each output transfer with
// the oldest expected colour. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module rgba_lut_linear_interp_checker #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [8:0]                      i_cfg_wdata,
    input  logic                            i_in_tvalid,
    input  logic                            i_in_tready,
    // tdata: entry_index, red_in, green_in, blue_in, alpha_in, query_value
    input  logic [rlli_pkg::IN_TDATA_W-1:0] i_in_tdata,
    // tuser: opcode
    input  logic                            i_in_tuser,
    input  logic                            i_out_tvalid,
    input  logic                            i_out_tready,
    // tdata: red, green, blue, alpha
    input  logic [63:0]                     i_out_tdata,
    // tuser: clamp_kind
    input  logic [1:0]                      i_out_tuser,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rlli_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_rgba  colour;
        t_clamp clamp;
    } t_lut_result;

    t_rgba       colour_store [TABLE_DEPTH];
    logic [8:0]  entries_cfg;
    t_lut_result expected_colours [$];

    // Map one query scalar onto the table: clamp below, clamp above, or blend
    // the two neighbouring entries with round-to-nearest.
    function automatic t_lut_result lookup_colour(input logic [31:0] value);
        t_lut_result res;
        int unsigned last;
        int unsigned lo;
        logic [63:0] scaled;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] unity;
        logic [63:0] acc;
        res.colour = ENTRY_ZERO;
        res.clamp  = CLAMP_NONE;
        if (value[31]) begin
            res.colour = colour_store[0];
            res.clamp  = CLAMP_LOW;
            return res;
        end
        if (entries_cfg < 2) begin
            last = 1;
        end else if (entries_cfg > TABLE_DEPTH) begin
            last = TABLE_DEPTH - 1;
        end else begin
            last = entries_cfg - 1;
        end
        unity  = 64'd1 << FRACTION_BITS;
        scaled = 64'(value) * 64'(last);
        whole  = scaled >> FRACTION_BITS;
        frac   = scaled & (unity - 64'd1);
        if (whole >= 64'(last)) begin
            res.colour = colour_store[last];
            res.clamp  = CLAMP_HIGH;
            return res;
        end
        lo = int'(whole);
        for (int c = 0; c < 4; c++) begin
            acc = 64'(colour_store[lo][c]) * (unity - frac)
                + 64'(colour_store[lo + 1][c]) * frac + (unity >> 1);
            res.colour[c] = 16'(acc >> FRACTION_BITS);
        end
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (o_fail_count < MAX_REPORTS) begin
            $display("mismatch on %s: expected %h, actual %h", field, want, got);
        end
        o_fail_count++;
    endtask

    // Track configuration and table writes, queue expected colours, compare
    // every output transfer against the oldest one.
    always @(posedge i_clk) begin
        t_lut_result want;
        t_rgba       got_colour;
        logic [7:0]  idx;
        if (!i_rst_n) begin
            for (int e = 0; e < TABLE_DEPTH; e++) begin
                colour_store[e] = ENTRY_ZERO;
            end
            colour_store[0] = ENTRY_BLACK;
            colour_store[1] = ENTRY_WHITE;
            entries_cfg     = 9'd2;
            expected_colours.delete();
        end else begin
            if (i_cfg_wen) begin
                entries_cfg = i_cfg_wdata;
            end
            if (i_in_tvalid && i_in_tready) begin
                if (i_in_tuser == OP_WRITE) begin
                    idx = i_in_tdata[IDX_LSB +: 8];
                    if (int'(idx) < TABLE_DEPTH) begin
                        colour_store[idx] = i_in_tdata[COLOR_LSB +: 64];
                    end
                end else begin
                    expected_colours.push_back(lookup_colour(i_in_tdata[QUERY_LSB +: 32]));
                end
            end
            if (i_out_tvalid && i_out_tready) begin
                if (expected_colours.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $display("unexpected result: actual colour %h clamp %0d",
                                 i_out_tdata, i_out_tuser);
                    end
                    o_fail_count++;
                end else begin
                    want       = expected_colours.pop_front();
                    got_colour = i_out_tdata;
                    for (int c = 0; c < 4; c++) begin
                        if (got_colour[c] !== want.colour[c]) begin
                            note_mismatch(c == 0 ? "red" : c == 1 ? "green" :
                                          c == 2 ? "blue" : "alpha",
                                          want.colour[c], got_colour[c]);
                        end
                    end
                    if (i_out_tuser !== want.clamp) begin
                        note_mismatch("clamp_kind", 16'(want.clamp), 16'(i_out_tuser));
                    end
                end
            end
        end
        o_pending = expected_colours.size();
    end

endmodule

// ===== dv/rgba_lut_linear_interp_test.sv =====
// ----------------------------------------------------------------------------
// rgba_lut_linear_interp_test
// Stimulus and verdict for the RGBA lookup table. A short directed run covers
// the clamp cases, zero, rounding at the half and table writes; then phases
// of random writes and queries run over several table sizes, extremes among
// them, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module rgba_lut_linear_interp_test;
    import rlli_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 148;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wen     = 1'b0;
    logic [8:0]            i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_QUERY;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int          fail_count;
    int          pending;
    bit          quiet       = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;

    rgba_lut_linear_interp DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rgba_lut_linear_interp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned gap_cycles();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_channel();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return 16'h0000;
        if (pick < 30) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Output side: stall at random; no new stall starts while quiet.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left <= gap_cycles();
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wen) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one item after a random gap and hold it until the transfer.
    task automatic send_item(input logic op, input logic [7:0] idx, input t_rgba colour,
                             input logic [31:0] value);
        int unsigned gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {value, colour, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_write(input logic [7:0] idx, input t_rgba colour);
        send_item(OP_WRITE, idx, colour, $urandom);
    endtask

    task automatic send_query(input logic [31:0] value);
        t_rgba noise;
        noise = {$urandom, $urandom};
        send_item(OP_QUERY, 8'($urandom), noise, value);
    endtask

    // One random item; queries mostly inside the table range.
    task automatic send_random(input int unsigned n_eff);
        int unsigned pick;
        logic [31:0] value;
        t_rgba       colour;
        logic [7:0]  idx;
        for (int c = 0; c < 4; c++) begin
            colour[c] = rand_channel();
        end
        if ($urandom_range(0, 4) != 0) begin
            idx = 8'($urandom_range(0, n_eff - 1));
        end else begin
            idx = 8'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            value = $urandom_range(0, 32'h0001_0000);
        end else if (pick < 70) begin
            value = {1'b1, 31'($urandom)};
        end else if (pick < 80) begin
            value = $urandom_range(32'h0001_0001, 32'h7FFF_FFFF);
        end else if (pick < 90) begin
            value = $urandom;
        end else begin
            case ($urandom_range(0, 5))
                0: value = 32'h0000_0000;
                1: value = 32'h7FFF_FFFF;
                2: value = 32'h8000_0000;
                3: value = 32'hFFFF_FFFF;
                4: value = 32'h0001_0000;
                default: value = 32'h0000_FFFF;
            endcase
        end
        send_item(($urandom_range(0, 99) < 35) ? OP_WRITE : OP_QUERY, idx, colour, value);
    endtask

    // Drop valid, wait for every expected colour, then let the pipe settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entries(input logic [8:0] n);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        logic [8:0]  phase_cfg [10];
        int unsigned n_eff;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the table clearing pass has finished
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        set_entries(9'd2);

        // Directed: clamps, zero, rounding at the half, writes at both ends.
        send_query(32'h0000_0000);
        send_query(32'hFFFF_FFFF);
        send_query(32'h8000_0000);
        send_query(32'h7FFF_FFFF);
        send_query(32'h0001_0000);
        send_query(32'h0000_FFFF);
        send_query(32'h0000_8000);
        send_query(32'h0000_0001);
        send_write(8'd0, 64'h0000_FFFF_0000_FFFF);
        send_write(8'd1, 64'hFFFF_0000_FFFF_0000);
        send_query(32'h0000_8000);
        send_query(32'h0000_4000);
        send_query(32'h0000_C000);
        send_write(8'd255, ENTRY_WHITE);
        send_write(8'd128, {$urandom, $urandom});
        send_write(8'd1, ENTRY_ZERO);
        send_query(32'h0000_7FFF);
        send_query(32'h0000_0000);
        send_query(32'hFFFF_8000);

        // Random phases over several table sizes, out-of-range values included.
        phase_cfg = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd3, 9'd17, 9'd257, 9'd2,
                      9'($urandom_range(2, 256)), 9'($urandom)};
        foreach (phase_cfg[p]) begin
            drain_results();
            set_entries(phase_cfg[p]);
            quiet = (p == 3) || ($urandom_range(0, 3) == 0);
            if (phase_cfg[p] < 2) begin
                n_eff = 2;
            end else if (phase_cfg[p] > 256) begin
                n_eff = 256;
            end else begin
                n_eff = phase_cfg[p];
            end
            repeat (PHASE_ITEMS) send_random(n_eff);
        end
        quiet = 1'b0;
        drain_results();

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rlli_pkg.sv
sv/rlli_ram.sv
sv/rlli_blend.sv
sv/rgba_lut_linear_interp.sv
dv/rgba_lut_linear_interp_checker.sv
dv/rgba_lut_linear_interp_test.sv
